// File: rtl/core/rsq_pkg.sv
`timescale 1ns / 1ps

package rsq_pkg;

  // Request codes carried in the input tuser field
  localparam logic [2:0] REQ_SAMPLE     = 3'd0;
  localparam logic [2:0] REQ_TAKE_CW    = 3'd1;
  localparam logic [2:0] REQ_TAKE_CCW   = 3'd2;
  localparam logic [2:0] REQ_TAKE_CLICK = 3'd3;
  localparam logic [2:0] REQ_CLEAR      = 3'd4;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_STEP_LIMIT    = 2'd0;
  localparam logic [1:0] REG_COUNTS_DETENT = 2'd1;
  localparam logic [1:0] REG_ROT_HOLDOFF   = 2'd2;
  localparam logic [1:0] REG_CLICK_HOLDOFF = 2'd3;

  localparam int unsigned LIMIT_W = 15;
  localparam int unsigned CPD_W   = 8;
  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned QUEUE_W = 16;
  localparam int unsigned RESID_W = 9;

  // Divider: 16-bit magnitude by 8-bit divisor, four quotient bits per cycle
  localparam int unsigned DVD_W         = 16;
  localparam int unsigned DIV_BITS_STEP = 4;
  localparam int unsigned DIV_ITERS     = DVD_W / DIV_BITS_STEP;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_ITERS);

  localparam logic [LIMIT_W-1:0] STEP_LIMIT_RST    = 15'd8;
  localparam logic [CPD_W-1:0]   COUNTS_DETENT_RST = 8'd4;
  localparam logic [HOLD_W-1:0]  ROT_HOLDOFF_RST   = 16'd0;
  localparam logic [HOLD_W-1:0]  CLICK_HOLDOFF_RST = 16'd200;

  typedef struct packed {
    logic [LIMIT_W-1:0] step_limit;
    logic [CPD_W-1:0]   detent_counts;
    logic [HOLD_W-1:0]  rotate_holdoff_ms;
    logic [HOLD_W-1:0]  click_holdoff_ms;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [CPD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [CPD_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ACC,
    ST_DIV,
    ST_FIN
  } state_e;

endpackage

// File: rtl/core/rsq_cfg.sv
`timescale 1ns / 1ps

module rsq_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [3:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output logic [31:0]        prdata_o,
  output rsq_pkg::cfg_t      cfg_o
);

  rsq_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign wr_en   = psel_i & penable_i & pwrite_i;
  assign reg_idx = paddr_i[3:2];

  // Write the addressed register in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_limit        <= rsq_pkg::STEP_LIMIT_RST;
      cfg_q.detent_counts     <= rsq_pkg::COUNTS_DETENT_RST;
      cfg_q.rotate_holdoff_ms <= rsq_pkg::ROT_HOLDOFF_RST;
      cfg_q.click_holdoff_ms  <= rsq_pkg::CLICK_HOLDOFF_RST;
    end else if (wr_en) begin
      case (reg_idx)
        rsq_pkg::REG_STEP_LIMIT:    cfg_q.step_limit <= pwdata_i[rsq_pkg::LIMIT_W-1:0];
        rsq_pkg::REG_COUNTS_DETENT: cfg_q.detent_counts <= pwdata_i[rsq_pkg::CPD_W-1:0];
        rsq_pkg::REG_ROT_HOLDOFF:   cfg_q.rotate_holdoff_ms <= pwdata_i[rsq_pkg::HOLD_W-1:0];
        rsq_pkg::REG_CLICK_HOLDOFF: cfg_q.click_holdoff_ms <= pwdata_i[rsq_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      rsq_pkg::REG_STEP_LIMIT:    prdata_o = {17'd0, cfg_q.step_limit};
      rsq_pkg::REG_COUNTS_DETENT: prdata_o = {24'd0, cfg_q.detent_counts};
      rsq_pkg::REG_ROT_HOLDOFF:   prdata_o = {16'd0, cfg_q.rotate_holdoff_ms};
      rsq_pkg::REG_CLICK_HOLDOFF: prdata_o = {16'd0, cfg_q.click_holdoff_ms};
      default:                    prdata_o = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/rsq_div.sv
`timescale 1ns / 1ps

module rsq_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsq_pkg::div_req_t req_i,
  output rsq_pkg::div_rsp_t rsp_o
);

  logic [rsq_pkg::DVD_W-1:0]     quo_q, quo_d;
  logic [rsq_pkg::CPD_W-1:0]     rem_q, rem_d;
  logic [rsq_pkg::CPD_W-1:0]     dvs_q;
  logic [rsq_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic                          last_iter;

  // Retire four quotient bits: shift in a dividend bit, compare, subtract
  always_comb begin
    logic [rsq_pkg::CPD_W:0]   r;
    logic [rsq_pkg::DVD_W-1:0] qv;
    r  = {1'b0, rem_q};
    qv = quo_q;
    for (int k = 0; k < rsq_pkg::DIV_BITS_STEP; k++) begin
      r  = {r[rsq_pkg::CPD_W-1:0], qv[rsq_pkg::DVD_W-1]};
      qv = {qv[rsq_pkg::DVD_W-2:0], 1'b0};
      if (r >= {1'b0, dvs_q}) begin
        r     = r - {1'b0, dvs_q};
        qv[0] = 1'b1;
      end
    end
    rem_d = r[rsq_pkg::CPD_W-1:0];
    quo_d = qv;
  end

  assign last_iter = (cnt_q == rsq_pkg::DIV_CNT_W'(rsq_pkg::DIV_ITERS - 1));

  // Sequence the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && last_iter;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_iter) busy_q <= 1'b0;
      end
    end
  end

  // Load operands on start, then advance the partial remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= (req_i.divisor == '0) ? rsq_pkg::CPD_W'(1) : req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: rtl/core/rotary_encoder_step_queue_unit.sv
`timescale 1ns / 1ps

// Channel    | Dir | Handshake              | Payload
// s_axis     | in  | tvalid/tready          | tuser req_type, tdata count/button/time
// m_axis     | out | tvalid/tready          | tdata taken/queued_steps/click_waiting
// apb        | in  | psel/penable/pwrite    | 4 registers at 0x0, 0x4, 0x8, 0xC
//
// A request is taken in IDLE and its result is written to the output register
// in FIN, after PREP; ready returns the cycle after. A sample with an
// accepted count change also runs the divider between PREP and FIN (ACC, 4
// iterations, then DIV picks up the result).
// FIN holds while the output register is full and not drained.
// Reset (rst_ni low) clears the architectural state, sequencer and output valid and loads register defaults.

module rotary_encoder_step_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // [31:0] encoder_count, [32] button_down,
                                     // [64:33] now_ms, [71:65] zero
  input  logic [2:0]  s_axis_tuser,  // [2:0] req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [0] taken, [16:1] queued_steps,
                                     // [17] click_waiting, [23:18] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned QW = rsq_pkg::QUEUE_W;
  localparam int unsigned RW = rsq_pkg::RESID_W;

  rsq_pkg::cfg_t     cfg;
  rsq_pkg::div_req_t div_req;
  rsq_pkg::div_rsp_t div_rsp;
  rsq_pkg::state_e   state_q, state_d;

  // Architectural state
  logic [31:0]           prev_count_q;
  logic signed [RW-1:0]  resid_q;
  logic signed [QW-1:0]  queue_q;
  logic [31:0]           last_step_q;
  logic                  prev_btn_q;
  logic [31:0]           last_click_q;
  logic                  click_pend_q;

  // Per-request working registers
  logic [2:0]            req_q;
  logic [31:0]           count_q;
  logic                  btn_q;
  logic [31:0]           now_q;
  logic signed [31:0]    delta_q;
  logic [31:0]           rot_elapsed_q;
  logic [31:0]           clk_elapsed_q;
  logic signed [QW-1:0]  delta_c_q;
  logic                  apply_q;
  logic                  click_q;
  logic                  acc_neg_q;
  logic signed [16:0]    whole_q;
  logic signed [RW-1:0]  resid_new_q;

  // Output register
  logic                  out_valid_q;
  logic                  out_taken_q;
  logic signed [QW-1:0]  out_queue_q;
  logic                  out_click_q;

  // Sequencer strobes
  logic accept;
  logic in_ready;
  logic div_start;
  logic commit;
  logic prep_en;
  logic res_en;

  logic                  apply_d;
  logic                  click_d;
  logic signed [31:0]    lim32;
  logic signed [31:0]    nlim32;
  logic signed [QW-1:0]  delta_c_d;
  logic signed [16:0]    acc;
  logic [15:0]           acc_mag;
  logic signed [17:0]    lim18;
  logic signed [17:0]    q_sum;
  logic signed [QW-1:0]  q_sat;
  logic signed [QW-1:0]  queue_n;
  logic signed [RW-1:0]  resid_n;
  logic                  taken_n;
  logic                  click_n;

  rsq_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  rsq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign pready = 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rsq_pkg::ST_IDLE: if (s_axis_tvalid) state_d = rsq_pkg::ST_PREP;
      rsq_pkg::ST_PREP: state_d = apply_d ? rsq_pkg::ST_ACC : rsq_pkg::ST_FIN;
      rsq_pkg::ST_ACC:  state_d = rsq_pkg::ST_DIV;
      rsq_pkg::ST_DIV:  if (div_rsp.done) state_d = rsq_pkg::ST_FIN;
      rsq_pkg::ST_FIN:  if (commit) state_d = rsq_pkg::ST_IDLE;
      default:          state_d = rsq_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    prep_en   = 1'b0;
    div_start = 1'b0;
    res_en    = 1'b0;
    commit    = 1'b0;
    case (state_q)
      rsq_pkg::ST_IDLE: in_ready  = 1'b1;
      rsq_pkg::ST_PREP: prep_en   = 1'b1;
      rsq_pkg::ST_ACC:  div_start = 1'b1;
      rsq_pkg::ST_DIV:  res_en    = div_rsp.done;
      rsq_pkg::ST_FIN:  commit    = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign s_axis_tready = in_ready;
  assign accept        = s_axis_tvalid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rsq_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // Capture the request and the wrapping differences
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q         <= s_axis_tuser;
      count_q       <= s_axis_tdata[31:0];
      btn_q         <= s_axis_tdata[32];
      now_q         <= s_axis_tdata[64:33];
      delta_q       <= $signed(s_axis_tdata[31:0] - prev_count_q);
      rot_elapsed_q <= s_axis_tdata[64:33] - last_step_q;
      clk_elapsed_q <= s_axis_tdata[64:33] - last_click_q;
    end
  end

  // Decide hold-offs and clamp the delta
  assign lim32  = $signed({17'd0, cfg.step_limit});
  assign nlim32 = -lim32;

  always_comb begin
    apply_d = (req_q == rsq_pkg::REQ_SAMPLE) && (delta_q != 0) &&
              !((last_step_q != '0) &&
                (rot_elapsed_q < {16'd0, cfg.rotate_holdoff_ms}));
    click_d = (req_q == rsq_pkg::REQ_SAMPLE) && btn_q && !prev_btn_q &&
              (clk_elapsed_q >= {16'd0, cfg.click_holdoff_ms});
    if (delta_q > lim32)       delta_c_d = lim32[QW-1:0];
    else if (delta_q < nlim32) delta_c_d = nlim32[QW-1:0];
    else                       delta_c_d = delta_q[QW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (prep_en) begin
      apply_q   <= apply_d;
      click_q   <= click_d;
      delta_c_q <= delta_c_d;
    end
  end

  // Add the residue and hand the magnitude to the divider
  assign acc     = $signed({{(17-RW){resid_q[RW-1]}}, resid_q}) +
                   $signed({delta_c_q[QW-1], delta_c_q});
  assign acc_mag = acc[16] ? 16'(-acc) : acc[15:0];

  assign div_req.start    = div_start;
  assign div_req.dividend = acc_mag;
  assign div_req.divisor  = cfg.detent_counts;

  always_ff @(posedge clk_i) begin
    if (div_start) acc_neg_q <= acc[16];
  end

  // Restore the dividend sign on quotient and remainder
  always_ff @(posedge clk_i) begin
    if (res_en) begin
      whole_q     <= acc_neg_q ? -$signed({1'b0, div_rsp.quotient})
                               :  $signed({1'b0, div_rsp.quotient});
      resid_new_q <= acc_neg_q ? -$signed({1'b0, div_rsp.remainder})
                               :  $signed({1'b0, div_rsp.remainder});
    end
  end

  // Saturate the queue after adding whole detents
  assign lim18 = $signed({3'd0, cfg.step_limit});
  assign q_sum = $signed({{2{queue_q[QW-1]}}, queue_q}) + $signed({whole_q[16], whole_q});

  always_comb begin
    if (q_sum > lim18)       q_sat = lim18[QW-1:0];
    else if (q_sum < -lim18) q_sat = 16'(-lim18);
    else                     q_sat = q_sum[QW-1:0];
  end

  // Work out the item's effect
  always_comb begin
    queue_n = queue_q;
    resid_n = resid_q;
    taken_n = 1'b0;
    click_n = click_pend_q;
    case (req_q)
      rsq_pkg::REQ_SAMPLE: begin
        if (apply_q) begin
          queue_n = q_sat;
          resid_n = resid_new_q;
        end
        if (click_q) click_n = 1'b1;
      end
      rsq_pkg::REQ_TAKE_CW: begin
        if (queue_q > 0) begin
          queue_n = queue_q - 16'sd1;
          taken_n = 1'b1;
        end
      end
      rsq_pkg::REQ_TAKE_CCW: begin
        if (queue_q < 0) begin
          queue_n = queue_q + 16'sd1;
          taken_n = 1'b1;
        end
      end
      rsq_pkg::REQ_TAKE_CLICK: begin
        if (click_pend_q) begin
          click_n = 1'b0;
          taken_n = 1'b1;
        end
      end
      rsq_pkg::REQ_CLEAR: begin
        queue_n = '0;
        resid_n = '0;
      end
      default: ;
    endcase
  end

  // Commit state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q <= '0;
      resid_q      <= '0;
      queue_q      <= '0;
      last_step_q  <= '0;
      prev_btn_q   <= 1'b0;
      last_click_q <= '0;
      click_pend_q <= 1'b0;
    end else if (commit) begin
      queue_q      <= queue_n;
      resid_q      <= resid_n;
      click_pend_q <= click_n;
      if (req_q == rsq_pkg::REQ_SAMPLE) begin
        prev_count_q <= count_q;
        prev_btn_q   <= btn_q;
        if (apply_q && (whole_q != 0)) last_step_q <= now_q;
        if (click_q) last_click_q <= now_q;
      end
    end
  end

  // Hold the result until the sink drains it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)           out_valid_q <= 1'b0;
    else if (commit)       out_valid_q <= 1'b1;
    else if (m_axis_tready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_taken_q <= taken_n;
      out_queue_q <= queue_n;
      out_click_q <= click_n;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_click_q, out_queue_q, out_taken_q};

`ifndef SYNTH
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_div_done_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsq_pkg::ST_DIV) && div_rsp.done |=> state_q == rsq_pkg::ST_FIN)
    else $error("divider result not taken to finish");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_q != -16'sd32768)
    else $error("step queue out of range");

  a_resid_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resid_q <= 9'sd254) && (resid_q >= -9'sd254))
    else $error("detent residue out of range");
`endif

endmodule
